@@ hw/rtl/ovr_pkg.sv @@
// Package with the shared types, constants and exact-division tables of the rank unit.
`timescale 1ns / 1ps

package ovr_pkg;

  localparam int unsigned MAX_MODES = 8;
  localparam int unsigned MAX_TOTAL = 31;

  localparam int unsigned RANK_W = 26;
  localparam int unsigned ACC_W  = 30;
  localparam int unsigned OCC_W  = 6;
  localparam int unsigned SUM_W  = 7;
  localparam int unsigned POS_W  = 4;
  localparam int unsigned K_W    = 3;
  localparam int unsigned BASE_W = 5;

  typedef struct packed {
    logic              start;
    logic [BASE_W-1:0] base;
    logic [K_W-1:0]    k;
  } bn_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } bn_rsp_t;

  // Exact division by j is a right shift by the trailing zeros of j followed
  // by a multiplication with the inverse of the odd part modulo 2^ACC_W.
  function automatic logic [1:0] div_shift(input logic [K_W-1:0] j);
    logic [1:0] sh;
    unique case (j)
      3'd2:    sh = 2'd1;
      3'd4:    sh = 2'd2;
      3'd6:    sh = 2'd1;
      default: sh = 2'd0;
    endcase
    return sh;
  endfunction

  function automatic logic [ACC_W-1:0] div_inv(input logic [K_W-1:0] j);
    logic [ACC_W-1:0] inv;
    unique case (j)
      3'd3:    inv = 30'h2AAA_AAAB;
      3'd5:    inv = 30'h0CCC_CCCD;
      3'd6:    inv = 30'h2AAA_AAAB;
      3'd7:    inv = 30'h36DB_6DB7;
      default: inv = 30'h0000_0001;
    endcase
    return inv;
  endfunction

endpackage

@@ hw/rtl/occupation_vector_rank_unit.sv @@
// Top level of the occupation vector rank unit: item intake, bound checks and result register.
`timescale 1ns / 1ps

// Mode counts arrive one item at a time, highest mode first, and the item with
// last set (mode 0) returns the rank of the vector within its fixed-total
// subspace together with an overflow flag; on overflow the rank reads 0. An
// item whose new running sum S is at least 1 at position i holds off the
// following items while C(S+i, i+1) is built on one shared multiplier that
// takes a multiply step and an exact-division step per factor. Every other
// item, including the last one, causes no multiplier stall. The finished
// result sits in an output register; while it waits to be taken no further
// item is accepted, but the next item may enter on the edge that takes it.
module occupation_vector_rank_unit
  import ovr_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic signed [OCC_W-1:0] occupation_i,
  input  logic                    last_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [RANK_W-1:0]       rank_o,
  output logic                    overflow_o
);

  localparam logic [POS_W-1:0] LastPos = POS_W'(MAX_MODES - 1);
  localparam int unsigned      ExtW    = SUM_W + 1;

  logic signed [SUM_W-1:0] sum_q, sum_d;
  logic [POS_W-1:0]        pos_q, pos_d;
  logic [RANK_W-1:0]       rank_acc_q, rank_acc_d;
  logic                    err_q, err_d;

  logic                    out_valid_q, out_valid_d;
  logic [RANK_W-1:0]       out_rank_q, out_rank_d;
  logic                    out_ovf_q, out_ovf_d;

  bn_req_t                 bn_req;
  bn_rsp_t                 bn_rsp;
  logic [RANK_W-1:0]       bn_value;

  logic                    in_fire;
  logic signed [ExtW-1:0]  new_sum;
  logic                    sum_bad;

  assign in_stall_o = bn_rsp.busy | (out_valid_q & out_stall_i);
  assign in_fire    = in_valid_i & ~in_stall_o;

  assign new_sum = ExtW'(sum_q) + ExtW'(occupation_i);
  assign sum_bad = (new_sum < -ExtW'(1)) || (new_sum > $signed(ExtW'(MAX_TOTAL)));

  always_comb begin
    sum_d       = sum_q;
    pos_d       = pos_q;
    rank_acc_d  = rank_acc_q;
    err_d       = err_q;
    out_valid_d = out_valid_q & out_stall_i;
    out_rank_d  = out_rank_q;
    out_ovf_d   = out_ovf_q;
    bn_req      = '0;

    if (bn_rsp.done) begin
      rank_acc_d = rank_acc_q + bn_value;
    end

    if (in_fire) begin
      priority if (last_i) begin
        out_valid_d = 1'b1;
        out_rank_d  = err_q ? '0 : rank_acc_q;
        out_ovf_d   = err_q;
        sum_d       = '0;
        pos_d       = '0;
        rank_acc_d  = '0;
        err_d       = 1'b0;
      end else if (pos_q >= LastPos) begin
        // Too many modes; the position saturates.
        err_d = 1'b1;
      end else begin
        pos_d = pos_q + POS_W'(1);
        if (!err_q) begin
          if (sum_bad) begin
            err_d = 1'b1;
          end else begin
            sum_d = new_sum[SUM_W-1:0];
            // C(S+i, i+1) is zero unless S is at least 1.
            if (new_sum > ExtW'(0)) begin
              bn_req.start = 1'b1;
              bn_req.base  = BASE_W'(new_sum - ExtW'(1));
              bn_req.k     = K_W'(pos_q + POS_W'(1));
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q       <= '0;
      pos_q       <= '0;
      rank_acc_q  <= '0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      sum_q       <= sum_d;
      pos_q       <= pos_d;
      rank_acc_q  <= rank_acc_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_rank_q <= out_rank_d;
    out_ovf_q  <= out_ovf_d;
  end

  ovr_binom u_binom (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (bn_req),
    .rsp_o   (bn_rsp),
    .value_o (bn_value)
  );

  assign out_valid_o = out_valid_q;
  assign rank_o      = out_rank_q;
  assign overflow_o  = out_ovf_q;

  a_ovf_rank_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && overflow_o |-> rank_o == '0)
    else $error("overflow result carries a nonzero rank");

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= LastPos)
    else $error("mode position ran past its limit");

  a_sum_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sum_q >= -SUM_W'(1) && sum_q <= $signed(SUM_W'(MAX_TOTAL)))
    else $error("running sum left its legal range");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bn_req.start |=> bn_rsp.busy && in_stall_o)
    else $error("binomial start did not hold off the next item");

endmodule

@@ hw/rtl/ovr_binom.sv @@
// Binomial coefficient unit: one shared multiplier alternates product and exact-division steps.
`timescale 1ns / 1ps

module ovr_binom
  import ovr_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bn_req_t           req_i,
  output bn_rsp_t           rsp_o,
  output logic [RANK_W-1:0] value_o
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_DONE = 4'b1000
  } bn_state_e;

  bn_state_e         state_q, state_d;
  logic [ACC_W-1:0]  acc_q, acc_d;
  logic [K_W-1:0]    j_q, j_d;
  logic [K_W-1:0]    k_q, k_d;
  logic [BASE_W-1:0] base_q, base_d;

  logic [ACC_W-1:0]  mul_a, mul_b, mul_p;

  // Operand selection for the single multiplier.
  always_comb begin
    mul_a = acc_q;
    mul_b = '0;
    unique case (state_q)
      ST_MUL: begin
        mul_b = ACC_W'(base_q) + ACC_W'(j_q);
      end
      ST_DIV: begin
        mul_a = acc_q >> div_shift(j_q);
        mul_b = div_inv(j_q);
      end
      default: begin
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // After step j the accumulator holds C(base + j, j).
  always_comb begin
    state_d = state_q;
    acc_d   = acc_q;
    j_d     = j_q;
    k_d     = k_q;
    base_d  = base_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_i.start) begin
          acc_d   = ACC_W'(1);
          j_d     = K_W'(1);
          k_d     = req_i.k;
          base_d  = req_i.base;
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        acc_d   = mul_p;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        acc_d = mul_p;
        if (j_q == k_q) begin
          state_d = ST_DONE;
        end else begin
          j_d     = j_q + K_W'(1);
          state_d = ST_MUL;
        end
      end
      ST_DONE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    j_q    <= j_d;
    k_q    <= k_d;
    base_q <= base_d;
  end

  assign rsp_o.busy = (state_q != ST_IDLE);
  assign rsp_o.done = (state_q == ST_DONE);
  assign value_o    = acc_q[RANK_W-1:0];

endmodule
